>>> rtl/assert_macros.svh
// Assertion helpers, clocked on a rising edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/mftt_pkg.sv
package mftt_pkg;

  // Fixed field widths
  localparam int ID_W        = 11;
  localparam int WRAP_W      = 13;
  localparam int LIMIT_W     = 19;
  localparam int MASK_W      = 8;
  localparam int OFFLINE_W   = 16;
  localparam int SLOT_FIELD_W = 3;
  localparam int ANGLE_MAX_W = 16;
  localparam int POS_W       = 33;
  localparam int TURNS_OUT_W = 20;
  localparam int SPEED_W     = 16;
  localparam int CURRENT_W   = 16;
  localparam int TEMP_W      = 8;
  localparam int IDLE_W      = 17;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 19;

  // Parameter defaults
  localparam int SLOTS_DEF      = 8;
  localparam int ANGLE_BITS_DEF = 13;
  localparam int TURN_BITS_DEF  = 20;

  // Queue depth, power of two
  localparam int QUEUE_DEPTH = 2;

  // Register reset values
  localparam logic [ID_W-1:0]      ID_BASE_RST     = 11'h201;
  localparam logic [WRAP_W-1:0]    WRAP_RST        = 13'd5500;
  localparam logic [LIMIT_W-1:0]   LIMIT_RST       = 19'd10000;
  localparam logic [MASK_W-1:0]    REBASE_MASK_RST = 8'h00;
  localparam logic [OFFLINE_W-1:0] OFFLINE_RST     = 16'd1000;
  localparam logic [MASK_W-1:0]    ENABLE_MASK_RST = 8'hFF;

  typedef enum logic [0:0] {
    CMD_FRAME = 1'b0,
    CMD_TICK  = 1'b1
  } cmd_e;

  typedef enum logic [0:0] {
    KIND_POS    = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ID_BASE     = 3'd0,
    CFG_WRAP        = 3'd1,
    CFG_LIMIT       = 3'd2,
    CFG_REBASE_MASK = 3'd3,
    CFG_OFFLINE     = 3'd4,
    CFG_ENABLE_MASK = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [ID_W-1:0]      id_base;
    logic [WRAP_W-1:0]    wrap;
    logic [LIMIT_W-1:0]   limit;
    logic [MASK_W-1:0]    rebase_mask;
    logic [OFFLINE_W-1:0] offline;
    logic [MASK_W-1:0]    enable_mask;
  } mftt_cfg_t;

  // Classified word between front and back
  typedef struct packed {
    cmd_e                    cmd;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [ANGLE_MAX_W-1:0]  angle;
    logic [SPEED_W-1:0]      speed;
    logic [CURRENT_W-1:0]    current;
    logic [TEMP_W-1:0]       temp;
  } mftt_word_t;

  typedef struct packed {
    kind_e                   kind;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [POS_W-1:0]        position;
    logic [TURNS_OUT_W-1:0]  turns;
    logic                    rebased;
    logic [TURNS_OUT_W-1:0]  rebase_turns;
    logic [SPEED_W-1:0]      speed;
    logic [CURRENT_W-1:0]    current;
    logic [TEMP_W-1:0]       temp;
    logic                    first_frame;
    logic [MASK_W-1:0]       offline_mask;
  } mftt_res_t;

endpackage

>>> rtl/mftt_queue.sv
module mftt_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int Depth = mftt_pkg::QUEUE_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  logic [WIDTH-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i & ~full_o;
  assign do_rd   = rd_i & ~empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = do_wr ? wptr_q + PtrW'(1) : wptr_q;
    rptr_d = do_rd ? rptr_q + PtrW'(1) : rptr_q;
    cnt_d  = cnt_q + CntW'(do_wr) - CntW'(do_rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

>>> rtl/mftt_cfg.sv
module mftt_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mftt_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mftt_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output mftt_pkg::mftt_cfg_t                 cfg_o
);

  mftt_pkg::mftt_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (mftt_pkg::cfg_idx_e'(cfg_index_i))
        mftt_pkg::CFG_ID_BASE:     cfg_d.id_base     = cfg_data_i[mftt_pkg::ID_W-1:0];
        mftt_pkg::CFG_WRAP:        cfg_d.wrap        = cfg_data_i[mftt_pkg::WRAP_W-1:0];
        mftt_pkg::CFG_LIMIT:       cfg_d.limit       = cfg_data_i[mftt_pkg::LIMIT_W-1:0];
        mftt_pkg::CFG_REBASE_MASK: cfg_d.rebase_mask = cfg_data_i[mftt_pkg::MASK_W-1:0];
        mftt_pkg::CFG_OFFLINE:     cfg_d.offline     = cfg_data_i[mftt_pkg::OFFLINE_W-1:0];
        mftt_pkg::CFG_ENABLE_MASK: cfg_d.enable_mask = cfg_data_i[mftt_pkg::MASK_W-1:0];
        default: ;  // unused index, dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.id_base     <= mftt_pkg::ID_BASE_RST;
      cfg_q.wrap        <= mftt_pkg::WRAP_RST;
      cfg_q.limit       <= mftt_pkg::LIMIT_RST;
      cfg_q.rebase_mask <= mftt_pkg::REBASE_MASK_RST;
      cfg_q.offline     <= mftt_pkg::OFFLINE_RST;
      cfg_q.enable_mask <= mftt_pkg::ENABLE_MASK_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> rtl/mftt_front.sv
module mftt_front #(
  parameter int SLOTS      = mftt_pkg::SLOTS_DEF,
  parameter int ANGLE_BITS = mftt_pkg::ANGLE_BITS_DEF
) (
  input  logic                               push_i,
  input  logic                               qfull_i,
  input  logic                               command_i,
  input  logic [mftt_pkg::ID_W-1:0]          can_id_i,
  input  logic [ANGLE_BITS-1:0]              angle_i,
  input  logic [mftt_pkg::SPEED_W-1:0]       speed_i,
  input  logic [mftt_pkg::CURRENT_W-1:0]     current_i,
  input  logic [mftt_pkg::TEMP_W-1:0]        temperature_i,
  input  logic [mftt_pkg::ID_W-1:0]          id_base_i,
  output logic                               wr_o,
  output mftt_pkg::mftt_word_t               word_o
);

  logic [mftt_pkg::ID_W-1:0] slot_full;
  logic                      known;
  logic                      is_tick;

  // Slot wraps modulo 2048; frames whose ids map past the last slot are dropped here
  assign slot_full = can_id_i - id_base_i;
  assign known     = (slot_full < mftt_pkg::ID_W'(SLOTS));
  assign is_tick   = (command_i == mftt_pkg::CMD_TICK);
  assign wr_o      = push_i & ~qfull_i & (is_tick | known);

  always_comb begin
    word_o         = '0;
    word_o.cmd     = is_tick ? mftt_pkg::CMD_TICK : mftt_pkg::CMD_FRAME;
    word_o.slot    = slot_full[mftt_pkg::SLOT_FIELD_W-1:0];
    word_o.angle   = mftt_pkg::ANGLE_MAX_W'(angle_i);
    word_o.speed   = speed_i;
    word_o.current = current_i;
    word_o.temp    = temperature_i;
  end

endmodule

>>> rtl/mftt_back.sv
module mftt_back #(
  parameter int SLOTS      = mftt_pkg::SLOTS_DEF,
  parameter int ANGLE_BITS = mftt_pkg::ANGLE_BITS_DEF,
  parameter int TURN_BITS  = mftt_pkg::TURN_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mftt_pkg::mftt_cfg_t  cfg_i,
  input  logic                 in_valid_i,
  input  mftt_pkg::mftt_word_t word_i,
  output logic                 in_take_o,
  input  logic                 out_full_i,
  output logic                 out_wr_o,
  output mftt_pkg::mftt_res_t  res_o
);

  localparam int SlotW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int DiffW  = ((ANGLE_BITS > mftt_pkg::WRAP_W) ? ANGLE_BITS : mftt_pkg::WRAP_W) + 2;
  localparam int CmpW   = ((TURN_BITS > mftt_pkg::LIMIT_W) ? TURN_BITS : mftt_pkg::LIMIT_W) + 1;
  localparam int IdleW  = mftt_pkg::IDLE_W;
  localparam int PosW   = mftt_pkg::POS_W;
  localparam int TurnsW = mftt_pkg::TURNS_OUT_W;
  localparam logic signed [TURN_BITS-1:0] TMax = {1'b0, {(TURN_BITS-1){1'b1}}};
  localparam logic signed [TURN_BITS-1:0] TMin = {1'b1, {(TURN_BITS-1){1'b0}}};
  localparam logic [IdleW-1:0] IdleMax = '1;

  logic [ANGLE_BITS-1:0]       last_q [SLOTS];
  logic signed [TURN_BITS-1:0] turn_q [SLOTS];
  logic [SLOTS-1:0]            seen_q;
  logic [IdleW-1:0]            idle_q [SLOTS];
  logic [IdleW-1:0]            idle_inc [SLOTS];

  logic                        fire, is_tick, first, over;
  logic [SlotW-1:0]            s;
  logic [ANGLE_BITS-1:0]       ang;
  logic signed [DiffW-1:0]     diff, thr;
  logic signed [TURN_BITS-1:0] t_cur, t_step, t_fin;
  logic signed [CmpW-1:0]      t_ext, lim;
  logic signed [TURN_BITS+ANGLE_BITS-1:0] pos_full;
  logic [mftt_pkg::MASK_W-1:0] mask;

  assign fire      = in_valid_i & ~out_full_i;
  assign in_take_o = fire;
  assign out_wr_o  = fire;
  assign is_tick   = (word_i.cmd == mftt_pkg::CMD_TICK);
  assign s         = word_i.slot[SlotW-1:0];
  assign ang       = word_i.angle[ANGLE_BITS-1:0];

  // Frame path: wrap detect, saturating step, optional rebase
  always_comb begin
    first = ~seen_q[s];
    t_cur = turn_q[s];
    diff  = $signed({{(DiffW-ANGLE_BITS){1'b0}}, ang})
          - $signed({{(DiffW-ANGLE_BITS){1'b0}}, last_q[s]});
    thr   = $signed({{(DiffW-mftt_pkg::WRAP_W){1'b0}}, cfg_i.wrap});
    t_step = t_cur;
    if (!first) begin
      if (diff < -thr) begin
        if (t_cur != TMax) t_step = t_cur + TURN_BITS'(1);
      end else if (diff > thr) begin
        if (t_cur != TMin) t_step = t_cur - TURN_BITS'(1);
      end
    end
    t_ext = CmpW'(t_step);
    lim   = $signed({{(CmpW-mftt_pkg::LIMIT_W){1'b0}}, cfg_i.limit});
    over  = cfg_i.rebase_mask[s] & ((t_ext > lim) || (t_ext < -lim));
    t_fin = over ? '0 : t_step;
    // angle < 2^ANGLE_BITS, so turns*2^ANGLE_BITS + angle is a concatenation
    pos_full = $signed({t_fin, ang});
  end

  // Tick path: age every slot, flag enabled idle ones
  always_comb begin
    mask = '0;
    for (int i = 0; i < SLOTS; i++) begin
      idle_inc[i] = (idle_q[i] == IdleMax) ? idle_q[i] : idle_q[i] + IdleW'(1);
      mask[i] = cfg_i.enable_mask[i] & (idle_inc[i] > IdleW'(cfg_i.offline));
    end
  end

  always_comb begin
    res_o = '0;
    if (is_tick) begin
      res_o.kind         = mftt_pkg::KIND_STATUS;
      res_o.offline_mask = mask;
    end else begin
      res_o.kind         = mftt_pkg::KIND_POS;
      res_o.slot         = mftt_pkg::SLOT_FIELD_W'(s);
      res_o.position     = PosW'(pos_full);
      res_o.turns        = TurnsW'(t_fin);
      res_o.rebased      = over;
      res_o.rebase_turns = over ? TurnsW'(t_step) : '0;
      res_o.speed        = word_i.speed;
      res_o.current      = word_i.current;
      res_o.temp         = word_i.temp;
      res_o.first_frame  = first;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        last_q[i] <= '0;
        turn_q[i] <= '0;
        idle_q[i] <= '0;
      end
    end else if (fire) begin
      if (is_tick) begin
        for (int i = 0; i < SLOTS; i++) begin
          idle_q[i] <= idle_inc[i];
        end
      end else begin
        last_q[s] <= ang;
        turn_q[s] <= t_fin;
        seen_q[s] <= 1'b1;
        idle_q[s] <= '0;
      end
    end
  end

endmodule

>>> rtl/motor_feedback_turn_tracker_top.sv
// Multi-turn encoder unwrap for up to SLOTS motor slots. Feedback frames and
// ticks go in through a queue-style port (push/full) and results come out of
// one (empty/pop). Sustained rate is one word per clock on both sides while
// nothing stalls; a pushed word passes the front-to-back queue, then the
// result queue. The front classifies each word (slot = can_id minus id_base,
// modulo 2048) and drops frames for unknown slots without a result; the back
// does the per-slot read-modify-write of angle, turn count, seen mark and
// idle counter combinationally, so back-to-back frames for the same slot need
// no forwarding. Two-word queues sit between front and back and ahead of the
// result ports; a stall on one side reaches the other only via a full queue.
// Configuration registers are written through the cfg port (always ready)
// and must only be written while the block is idle.
module motor_feedback_turn_tracker_top #(
  parameter int SLOTS      = mftt_pkg::SLOTS_DEF,
  parameter int ANGLE_BITS = mftt_pkg::ANGLE_BITS_DEF,
  parameter int TURN_BITS  = mftt_pkg::TURN_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration write channel
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [mftt_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [mftt_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  // input queue side
  input  logic                                  push,
  output logic                                  full,
  input  logic                                  command_i,
  input  logic [mftt_pkg::ID_W-1:0]             can_id_i,
  input  logic [ANGLE_BITS-1:0]                 angle_i,
  input  logic signed [mftt_pkg::SPEED_W-1:0]   speed_i,
  input  logic signed [mftt_pkg::CURRENT_W-1:0] current_i,
  input  logic [mftt_pkg::TEMP_W-1:0]           temperature_i,
  // result queue side
  output logic                                  empty,
  input  logic                                  pop,
  output logic                                  kind_o,
  output logic [mftt_pkg::SLOT_FIELD_W-1:0]     slot_o,
  output logic signed [mftt_pkg::POS_W-1:0]     position_o,
  output logic signed [mftt_pkg::TURNS_OUT_W-1:0] turns_o,
  output logic                                  rebased_o,
  output logic signed [mftt_pkg::TURNS_OUT_W-1:0] rebase_turns_o,
  output logic signed [mftt_pkg::SPEED_W-1:0]   speed_out_o,
  output logic signed [mftt_pkg::CURRENT_W-1:0] current_out_o,
  output logic [mftt_pkg::TEMP_W-1:0]           temperature_out_o,
  output logic                                  first_frame_o,
  output logic [mftt_pkg::MASK_W-1:0]           offline_mask_o
);

  localparam int WordW = $bits(mftt_pkg::mftt_word_t);
  localparam int ResW  = $bits(mftt_pkg::mftt_res_t);

  mftt_pkg::mftt_cfg_t  cfg;
  mftt_pkg::mftt_word_t fr_word, bk_word;
  mftt_pkg::mftt_res_t  bk_res, out_res;
  logic                 fr_wr, mid_full, mid_empty, bk_take, out_full, out_wr;
  logic [WordW-1:0]     mid_rdata;
  logic [ResW-1:0]      out_rdata;

  // The input side is full exactly when the front-to-back queue is.
  assign full = mid_full;

  mftt_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  mftt_front #(
    .SLOTS      (SLOTS),
    .ANGLE_BITS (ANGLE_BITS)
  ) u_front (
    .push_i        (push),
    .qfull_i       (mid_full),
    .command_i     (command_i),
    .can_id_i      (can_id_i),
    .angle_i       (angle_i),
    .speed_i       (speed_i),
    .current_i     (current_i),
    .temperature_i (temperature_i),
    .id_base_i     (cfg.id_base),
    .wr_o          (fr_wr),
    .word_o        (fr_word)
  );

  // Classified words waiting for the back end
  mftt_queue #(
    .WIDTH (WordW)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (fr_wr),
    .wdata_i (fr_word),
    .full_o  (mid_full),
    .rd_i    (bk_take),
    .rdata_o (mid_rdata),
    .empty_o (mid_empty)
  );

  assign bk_word = mftt_pkg::mftt_word_t'(mid_rdata);

  mftt_back #(
    .SLOTS      (SLOTS),
    .ANGLE_BITS (ANGLE_BITS),
    .TURN_BITS  (TURN_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (~mid_empty),
    .word_i     (bk_word),
    .in_take_o  (bk_take),
    .out_full_i (out_full),
    .out_wr_o   (out_wr),
    .res_o      (bk_res)
  );

  // Finished results, oldest on the ports
  mftt_queue #(
    .WIDTH (ResW)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (out_wr),
    .wdata_i (bk_res),
    .full_o  (out_full),
    .rd_i    (pop),
    .rdata_o (out_rdata),
    .empty_o (empty)
  );

  assign out_res           = mftt_pkg::mftt_res_t'(out_rdata);
  assign kind_o            = out_res.kind;
  assign slot_o            = out_res.slot;
  assign position_o        = out_res.position;
  assign turns_o           = out_res.turns;
  assign rebased_o         = out_res.rebased;
  assign rebase_turns_o    = out_res.rebase_turns;
  assign speed_out_o       = out_res.speed;
  assign current_out_o     = out_res.current;
  assign temperature_out_o = out_res.temp;
  assign first_frame_o     = out_res.first_frame;
  assign offline_mask_o    = out_res.offline_mask;

endmodule

>>> rtl/mftt_checker.sv
`include "assert_macros.svh"

module mftt_checker (
  input logic                                    clk_i,
  input logic                                    rst_ni,
  input logic                                    empty,
  input logic                                    pop,
  input logic                                    kind_o,
  input logic [mftt_pkg::SLOT_FIELD_W-1:0]       slot_o,
  input logic signed [mftt_pkg::POS_W-1:0]       position_o,
  input logic signed [mftt_pkg::TURNS_OUT_W-1:0] turns_o,
  input logic                                    rebased_o,
  input logic signed [mftt_pkg::TURNS_OUT_W-1:0] rebase_turns_o,
  input logic                                    first_frame_o,
  input logic [mftt_pkg::MASK_W-1:0]             offline_mask_o
);

  // status words carry only the mask
  `ASSERT_CLKD(a_status_clean, clk_i, rst_ni, (!empty && kind_o == mftt_pkg::KIND_STATUS) |-> (slot_o == 0 && position_o == 0 && turns_o == 0 && rebased_o == 1'b0 && first_frame_o == 1'b0), "status word with position fields set")

  // position words carry no mask, and removed turns only on a rebase
  `ASSERT_CLKD(a_pos_clean, clk_i, rst_ni, (!empty && kind_o == mftt_pkg::KIND_POS) |-> (offline_mask_o == 0 && (rebased_o || rebase_turns_o == 0)), "position word with stray fields")

  // a rebase leaves a zero count with a nonzero removed amount
  `ASSERT_CLKD(a_rebase_zero, clk_i, rst_ni, (!empty && rebased_o) |-> (turns_o == 0 && rebase_turns_o != 0), "rebase left turns behind")

  // a waiting result that is not taken stays put
  `ASSERT_CLKD(a_hold, clk_i, rst_ni, (!empty && !pop) |=> (!empty && $stable(position_o) && $stable(kind_o)), "stalled result changed")

  // nothing to read while in reset
  `ASSERT_ALWAYS(a_rst_empty, clk_i, !rst_ni |-> empty, "result shown during reset")

endmodule

bind motor_feedback_turn_tracker_top mftt_checker u_mftt_checker (.*);
